### rtl/core/trace_record_parser_stats_core_macros.svh
// Assertion macros for the trace record parser.
`ifndef TRACE_RECORD_PARSER_STATS_CORE_MACROS_SVH
`define TRACE_RECORD_PARSER_STATS_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TRPS_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define TRPS_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("forbidden condition");
`else
`define TRPS_ASSERT_IMPL(label, clk, rst, prop)
`define TRPS_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### rtl/core/trps_pkg.sv
package trps_pkg;
   localparam int CounterWidth = 48;
   localparam int SizeBins = 7;
   localparam int NumCounters = 18;
   localparam logic [31:0] FileMagic = 32'h4654_5343;
   localparam logic [6:0] ValueCap = 7'd64;

   typedef enum logic [3:0] {
      PH_FILE, PH_RHDR, PH_IP, PH_IBYTES, PH_MADDR, PH_MPA, PH_MSIZE,
      PH_MFLAGS, PH_VALUE, PH_QUIET, PH_ERROR, PH_ENDED
   } phase_type;

   typedef enum logic [1:0] {
      KIND_RECORD = 2'd0, KIND_STOP = 2'd1, KIND_COUNTER = 2'd2
   } kind_type;

   localparam logic [3:0] ERR_NONE = 4'd0;
   localparam logic [3:0] ERR_SHORT_HDR = 4'd1;
   localparam logic [3:0] ERR_MAGIC = 4'd2;
   localparam logic [3:0] ERR_VERSION = 4'd3;
   localparam logic [3:0] ERR_ARCH = 4'd4;
   localparam logic [3:0] ERR_SIZE = 4'd5;
   localparam logic [3:0] ERR_TRUNC_ADDR = 4'd7;
   localparam logic [3:0] ERR_TRUNC_INSN = 4'd8;
   localparam logic [3:0] ERR_TRUNC_MEMOP = 4'd9;
   localparam logic [3:0] ERR_VALUE_FLAG = 4'd10;
   localparam logic [3:0] ERR_TRUNC_VALUE = 4'd11;

   localparam logic [4:0] CNT_RECORDS = 5'd0;
   localparam logic [4:0] CNT_USER = 5'd1;
   localparam logic [4:0] CNT_KERNEL = 5'd2;
   localparam logic [4:0] CNT_MEMOPS = 5'd3;
   localparam logic [4:0] CNT_READS = 5'd4;
   localparam logic [4:0] CNT_WRITES = 5'd5;
   localparam logic [4:0] CNT_VALUES = 5'd6;
   localparam logic [4:0] CNT_TAKEN = 5'd7;
   localparam logic [4:0] CNT_PA_VALID = 5'd8;
   localparam logic [4:0] CNT_PA_MMIO = 5'd9;
   localparam logic [4:0] CNT_SANITY = 5'd10;
   localparam logic [4:0] CNT_BIN0 = 5'd11;

   function automatic logic [2:0] size_bin(input logic [7:0] s);
      logic [2:0] idx;
      idx = 3'd0;
      for (int k = 1; k < SizeBins; k++) begin
         if (s >= (8'd1 << k)) begin
            idx = 3'(k);
         end
      end
      return idx;
   endfunction
endpackage

### rtl/core/trace_record_parser_stats_core.sv
// Byte-stream trace parser: one beat (a byte or an end-of-stream mark) is taken per cycle
// while the output is free and no dump runs. Each byte updates the parser and its counters
// in a single registered pass, so a byte yields at most one result, valid in the cycle after
// the byte is taken. End of stream yields a stop result (none after an error stop or an
// earlier end), then the 18 statistics counters from a small sequencer, one per cycle while
// unstalled, holding off input until the last. Results leave through a one-entry output register.
`include "trace_record_parser_stats_core_macros.svh"
module trace_record_parser_stats_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [47:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_error_code,
   output logic [4:0]  rsp_counter_index,
   output logic [47:0] rsp_counter_value,
   output logic [3:0]  rsp_vcpu,
   output logic        rsp_privileged,
   output logic [3:0]  rsp_insn_len,
   output logic [2:0]  rsp_mem_op_count,
   output logic [63:0] rsp_instr_address,
   output logic        rsp_branch_taken,
   output logic        rsp_last
);
   import trps_pkg::*;

   localparam logic [CounterWidth-1:0] CntMax = '1;

   logic [47:0] limit_ff;
   phase_type phase_ff, phase_in;
   logic [6:0] pos_ff, pos_in;
   logic [63:0] shift_ff, shift_in;
   logic [11:0] rhdr_ff, rhdr_in;
   logic [63:0] prev_addr_ff, prev_addr_in;
   logic [3:0] last_len_ff, last_len_in;
   logic have_prev_ff, have_prev_in;
   logic [2:0] mode_ff, mode_in;
   logic [2:0] ops_ff, ops_in;
   logic [15:0] osf_ff, osf_in;
   logic halted_ff, halted_in;
   logic taken_ff, taken_in;
   logic [CounterWidth-1:0] stat_ff [NumCounters];
   logic [NumCounters-1:0] bump;

   // End-of-stream sequencer.
   logic dump_ff;
   logic [4:0] dump_idx_ff;

   // Output register.
   logic ov_ff;
   logic [1:0] o_kind_ff;
   logic [3:0] o_err_ff, o_vcpu_ff, o_isz_ff;
   logic [4:0] o_idx_ff;
   logic [47:0] o_val_ff;
   logic o_priv_ff, o_taken_ff, o_last_ff;
   logic [2:0] o_mops_ff;
   logic [63:0] o_addr_ff;

   logic emit_rec, emit_stop;
   logic [3:0] stop_code;
   logic out_free, take;
   logic [6:0] pos_p1;
   logic [3:0] isz;
   logic [3:0] stop_code_end;
   logic end_has_stop;

   assign out_free = !ov_ff || rsp_ready;
   assign req_ready = out_free && !dump_ff;
   assign take = req_valid && req_ready;
   assign pos_p1 = pos_ff + 7'd1;
   assign isz = rhdr_ff[8:5];

   always_comb begin
      logic [7:0] b;
      logic [7:0] fl;
      logic [6:0] n;
      phase_type after_op;
      b = req_data_byte;
      phase_in = phase_ff; pos_in = pos_ff; shift_in = shift_ff; rhdr_in = rhdr_ff;
      prev_addr_in = prev_addr_ff; last_len_in = last_len_ff; have_prev_in = have_prev_ff;
      mode_in = mode_ff; ops_in = ops_ff; osf_in = osf_ff; halted_in = halted_ff;
      taken_in = taken_ff; bump = '0; emit_rec = 1'b0; emit_stop = 1'b0;
      stop_code = ERR_NONE; fl = 8'd0; n = 7'd0; after_op = PH_MADDR;
      if (take && req_action) begin
         phase_in = PH_ENDED;
         halted_in = 1'b1;
      end else if (take && !halted_ff) begin
         unique case (phase_ff)
            PH_FILE: begin
               if (pos_ff < 7'd8) shift_in[pos_ff[2:0]*8 +: 8] = b;
               else if (pos_ff == 7'd12) osf_in = {8'd0, b};
               else if (pos_ff == 7'd13) osf_in = {b, osf_ff[7:0]};
               pos_in = pos_p1;
               if (pos_p1 == 7'd16) begin
                  if (shift_ff[31:0] != FileMagic) begin
                     emit_stop = 1'b1; stop_code = ERR_MAGIC;
                  end else if (shift_ff[63:32] != 32'd2 && shift_ff[63:32] != 32'd3) begin
                     emit_stop = 1'b1; stop_code = ERR_VERSION;
                  end else if (shift_ff[63:32] == 32'd3 && osf_ff[7:0] > 8'd1) begin
                     emit_stop = 1'b1; stop_code = ERR_ARCH;
                  end else begin
                     mode_in = (shift_ff[63:32] == 32'd3) ?
                               {osf_ff[0], osf_ff[9:8]} : 3'b010;
                     phase_in = PH_RHDR; pos_in = '0; shift_in = '0; osf_in = '0;
                  end
               end
            end
            PH_RHDR: begin
               if (pos_ff == 7'd0 && limit_ff != 48'd0 && stat_ff[0] >= limit_ff) begin
                  phase_in = PH_QUIET; halted_in = 1'b1;
               end else begin
                  if (pos_ff == 7'd0) rhdr_in = {4'd0, b};
                  else if (pos_ff == 7'd1) rhdr_in = {b[3:0], rhdr_ff[7:0]};
                  pos_in = pos_p1;
                  if (pos_p1 == 7'd4) begin
                     if (rhdr_ff[8:5] == 4'd0) begin
                        emit_stop = 1'b1; stop_code = ERR_SIZE;
                     end else begin
                        bump[CNT_SANITY] = mode_ff[2] && rhdr_ff[8:5] != 4'd4;
                        phase_in = PH_IP; pos_in = '0; shift_in = '0;
                     end
                  end
               end
            end
            PH_IP: begin
               shift_in[pos_ff[2:0]*8 +: 8] = b;
               pos_in = pos_p1;
               if (pos_p1 >= 7'd8) begin
                  phase_in = PH_IBYTES; pos_in = '0;
               end
            end
            PH_IBYTES: begin
               pos_in = pos_p1;
               if (pos_p1 >= {3'd0, isz}) begin
                  taken_in = have_prev_ff &&
                             shift_ff != prev_addr_ff + {60'd0, last_len_ff};
                  bump[CNT_TAKEN] = taken_in;
                  prev_addr_in = shift_ff; last_len_in = isz; have_prev_in = 1'b1;
                  ops_in = rhdr_ff[11:9]; pos_in = '0;
                  if (rhdr_ff[11:9] == 3'd0) emit_rec = 1'b1;
                  else phase_in = PH_MADDR;
               end
            end
            PH_MADDR, PH_MPA: begin
               pos_in = pos_p1;
               if (pos_p1 >= 7'd8) begin
                  pos_in = '0;
                  phase_in = (phase_ff == PH_MADDR && mode_ff[0]) ? PH_MPA : PH_MSIZE;
               end
            end
            PH_MSIZE: begin
               osf_in = {8'd0, b}; phase_in = PH_MFLAGS;
            end
            PH_MFLAGS: begin
               osf_in = {b, osf_ff[7:0]};
               if (b[1] && !mode_ff[1]) begin
                  emit_stop = 1'b1; stop_code = ERR_VALUE_FLAG;
               end else begin
                  bump[CNT_PA_VALID] = b[2];
                  bump[CNT_PA_MMIO] = b[3];
                  bump[CNT_BIN0 + 5'(size_bin(osf_ff[7:0]))] = 1'b1;
                  n = (osf_ff[7:0] <= {1'b0, ValueCap}) ? osf_ff[6:0] : ValueCap;
                  if (b[1] && n != 7'd0) begin
                     pos_in = n; phase_in = PH_VALUE;
                  end else begin
                     fl = b;
                  end
               end
            end
            PH_VALUE: begin
               pos_in = pos_ff - 7'd1;
               if (pos_in == 7'd0) fl = osf_ff[15:8];
            end
            default: ;
         endcase
         // Memory operation finish, shared by the flags and value phases.
         if ((phase_ff == PH_MFLAGS && phase_in == PH_MFLAGS && !emit_stop) ||
             (phase_ff == PH_VALUE && pos_in == 7'd0)) begin
            bump[CNT_VALUES] = fl[1];
            bump[CNT_MEMOPS] = 1'b1;
            bump[fl[0] ? CNT_WRITES : CNT_READS] = 1'b1;
            ops_in = ops_ff - 3'd1; pos_in = '0;
            if (ops_in == 3'd0) emit_rec = 1'b1;
            else phase_in = after_op;
         end
         if (emit_rec) begin
            bump[CNT_RECORDS] = 1'b1;
            bump[rhdr_ff[4] ? CNT_KERNEL : CNT_USER] = 1'b1;
            phase_in = PH_RHDR; pos_in = '0;
         end
         if (emit_stop) begin
            phase_in = PH_ERROR; halted_in = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_FILE: stop_code_end = ERR_SHORT_HDR;
         PH_IP: stop_code_end = ERR_TRUNC_ADDR;
         PH_IBYTES: stop_code_end = ERR_TRUNC_INSN;
         PH_MADDR, PH_MPA, PH_MSIZE, PH_MFLAGS: stop_code_end = ERR_TRUNC_MEMOP;
         PH_VALUE: stop_code_end = ERR_TRUNC_VALUE;
         default: stop_code_end = ERR_NONE;
      endcase
   end
   assign end_has_stop = phase_ff != PH_ERROR && phase_ff != PH_ENDED;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0; phase_ff <= PH_FILE; pos_ff <= '0; shift_ff <= '0; rhdr_ff <= '0;
         prev_addr_ff <= '0; last_len_ff <= '0; have_prev_ff <= 1'b0; mode_ff <= '0;
         ops_ff <= '0; osf_ff <= '0; halted_ff <= 1'b0; taken_ff <= 1'b0;
         for (int i = 0; i < NumCounters; i++) stat_ff[i] <= '0;
         dump_ff <= 1'b0; dump_idx_ff <= '0; ov_ff <= 1'b0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         phase_ff <= phase_in; pos_ff <= pos_in; shift_ff <= shift_in; rhdr_ff <= rhdr_in;
         prev_addr_ff <= prev_addr_in; last_len_ff <= last_len_in;
         have_prev_ff <= have_prev_in; mode_ff <= mode_in; ops_ff <= ops_in;
         osf_ff <= osf_in; halted_ff <= halted_in; taken_ff <= taken_in;
         for (int i = 0; i < NumCounters; i++) begin
            if (bump[i] && stat_ff[i] != CntMax) stat_ff[i] <= stat_ff[i] + 1'b1;
         end
         if (rsp_ready) ov_ff <= 1'b0;
         if (dump_ff && out_free) begin
            ov_ff <= 1'b1;
            o_kind_ff <= KIND_COUNTER; o_err_ff <= ERR_NONE; o_idx_ff <= dump_idx_ff;
            o_val_ff <= stat_ff[dump_idx_ff];
            o_vcpu_ff <= '0; o_priv_ff <= 1'b0; o_isz_ff <= '0; o_mops_ff <= '0;
            o_addr_ff <= '0; o_taken_ff <= 1'b0;
            o_last_ff <= dump_idx_ff == 5'(NumCounters - 1);
            dump_idx_ff <= dump_idx_ff + 5'd1;
            if (dump_idx_ff == 5'(NumCounters - 1)) dump_ff <= 1'b0;
         end else if (take && (req_action || emit_rec || emit_stop)) begin
            o_idx_ff <= '0; o_val_ff <= '0; o_vcpu_ff <= '0; o_priv_ff <= 1'b0;
            o_isz_ff <= '0; o_mops_ff <= '0; o_addr_ff <= '0; o_taken_ff <= 1'b0;
            o_last_ff <= 1'b1; o_err_ff <= ERR_NONE;
            if (req_action) begin
               dump_ff <= 1'b1; dump_idx_ff <= '0;
               ov_ff <= end_has_stop;
               o_kind_ff <= KIND_STOP; o_err_ff <= stop_code_end; o_last_ff <= 1'b0;
            end else if (emit_stop) begin
               ov_ff <= 1'b1; o_kind_ff <= KIND_STOP; o_err_ff <= stop_code;
            end else begin
               ov_ff <= 1'b1; o_kind_ff <= KIND_RECORD;
               o_vcpu_ff <= rhdr_ff[3:0]; o_priv_ff <= rhdr_ff[4];
               o_isz_ff <= rhdr_ff[8:5]; o_mops_ff <= rhdr_ff[11:9];
               o_addr_ff <= prev_addr_in; o_taken_ff <= taken_in;
            end
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = o_kind_ff;
   assign rsp_error_code = o_err_ff;
   assign rsp_counter_index = o_idx_ff;
   assign rsp_counter_value = o_val_ff;
   assign rsp_vcpu = o_vcpu_ff;
   assign rsp_privileged = o_priv_ff;
   assign rsp_insn_len = o_isz_ff;
   assign rsp_mem_op_count = o_mops_ff;
   assign rsp_instr_address = o_addr_ff;
   assign rsp_branch_taken = o_taken_ff;
   assign rsp_last = o_last_ff;

   `TRPS_ASSERT_NEVER(a_no_take_in_dump, clock, reset, dump_ff && req_ready)
   `TRPS_ASSERT_IMPL(a_halt_sticky, clock, reset, halted_ff && !(take && req_action) |=> halted_ff)
   `TRPS_ASSERT_NEVER(a_one_result, clock, reset, emit_rec && emit_stop)
   `TRPS_ASSERT_IMPL(a_dump_ends, clock, reset, dump_ff && out_free && dump_idx_ff == 5'(NumCounters - 1) |=> !dump_ff)
endmodule
